FILE: hw/rtl/fctu_pkg.sv
// Package for the flow counter table unit: codes, field widths and defaults.
// No dependencies; used by the top level and the testbench by scoped names.
package fctu_pkg;

	// default table depth
	localparam int unsigned TABLE_DEPTH_DEF = 1024;

	// widths of the window arithmetic (index plus one carry bit)
	localparam int unsigned IDX_W = 16;
	localparam int unsigned WIN_W = 17;
	localparam int unsigned CNT_CFG_W = 11;
	localparam int unsigned CTR_W = 64;
	localparam int unsigned DELTA_W = 32;

	// stream widths
	localparam int unsigned IN_DATA_W = 88;
	localparam int unsigned OUT_DATA_W = 160;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_COUNT = 8'd1;

	// operations
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_INCR = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

endpackage

FILE: hw/rtl/flow_counter_table_unit.sv
// Top level of the flow counter table: sequencer, window logic, stores.
// Depends on fctu_pkg, fctu_ram and fctu_add.
//
// channel  direction  handshake            payload
// s_*      in         s_tvalid / s_tready  s_tdata: operation, index, deltas
// m_*      out        m_tvalid / m_tready  m_tdata: status .. index_in_range
// cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// After reset the used-flag memory is cleared, entry by entry, with s_tready low.
// Free, read and not-allocated items pass S_OCHK and S_FIN, an index outside the window
// S_FIN only, increment S_OCHK, S_ADDP, S_ADDB and S_FIN, set by the single read port
// of the stores and the one shared adder. Allocate does S_ARD (read) and S_ACHK (check)
// per used-flag entry probed, up to the window size, then S_FIN; an empty window S_FIN only.
// A finished result waits in the output register; a stall there holds the sequencer.
module flow_counter_table_unit #(
	parameter int unsigned TABLE_DEPTH = fctu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] operation, [17:2] index, [49:18] bytes_delta,
	// [81:50] packets_delta, [87:82] zero
	input  logic [fctu_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] status, [17:2] allocated_index, [81:18] packet_total,
	// [145:82] byte_total, [156:146] occupancy, [157] index_in_range, [159:158] zero
	output logic [fctu_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fctu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fctu_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned UCW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned WW = fctu_pkg::WIN_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [WW-1:0] DEPTH_W = WW'(TABLE_DEPTH);
	localparam logic [WW-1:0] SPACE_W = WW'(65536);

	// sequencer states
	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ARD = 3'd2;
	localparam logic [2:0] S_ACHK = 3'd3;
	localparam logic [2:0] S_OCHK = 3'd4;
	localparam logic [2:0] S_ADDP = 3'd5;
	localparam logic [2:0] S_ADDB = 3'd6;
	localparam logic [2:0] S_FIN = 3'd7;

	logic [2:0] state_q;

	// configuration
	logic [15:0] start_q;
	logic [10:0] count_q;

	// block state
	logic [15:0]    cursor_q;
	logic [UCW-1:0] used_q;
	logic [AW-1:0]  clr_q;

	// item registers
	logic [1:0]  op_q;
	logic [31:0] bdelta_q;
	logic [31:0] pdelta_q;
	logic        inrange_q;
	logic [AW-1:0] p_q;
	logic [WW-1:0] k_q;
	logic [127:0]  ctr_q;
	logic [63:0]   psum_q;

	// pending result
	logic [1:0]  r_status_q;
	logic [15:0] r_alloc_q;
	logic [63:0] r_ptot_q;
	logic [63:0] r_btot_q;

	// output register
	logic                            m_tvalid_q;
	logic [fctu_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// input fields
	logic [1:0]  in_op;
	logic [15:0] in_idx;
	logic [31:0] in_bd;
	logic [31:0] in_pd;
	assign in_op  = s_tdata[1:0];
	assign in_idx = s_tdata[17:2];
	assign in_bd  = s_tdata[49:18];
	assign in_pd  = s_tdata[81:50];

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// effective window size
	logic [WW-1:0] n_w;
	logic [WW-1:0] room_w;
	logic [WW-1:0] n_a;
	assign room_w = SPACE_W - WW'(start_q);
	assign n_a = (WW'(count_q) > DEPTH_W) ? DEPTH_W : WW'(count_q);
	assign n_w = (n_a > room_w) ? room_w : n_a;

	// slot of the incoming index
	logic [WW-1:0] off_w;
	logic          in_ge;
	logic          in_ok;
	assign in_ge = (in_idx >= start_q);
	assign off_w = WW'(in_idx) - WW'(start_q);
	assign in_ok = in_ge && (off_w < n_w);

	// first slot of the allocate search
	logic [WW-1:0] cur_off;
	logic [AW-1:0] first_slot;
	assign cur_off = WW'(cursor_q) - WW'(start_q);
	assign first_slot = ((cursor_q >= start_q) && (cur_off < n_w)) ? cur_off[AW-1:0] : '0;

	// next probe slot with wrap at the window end
	logic [AW-1:0] p_next;
	assign p_next = ((WW'(p_q) + WW'(1)) == n_w) ? '0 : p_q + AW'(1);

	// store ports
	logic          used_we;
	logic          used_wd;
	logic [AW-1:0] used_wa;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          used_rd;
	logic          ctr_we;
	logic [127:0]  ctr_wd;
	logic [127:0]  ctr_rd;

	fctu_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_wa),
		.wdata (used_wd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (used_rd)
	);

	// packet counter in the upper half, byte counter in the lower half
	fctu_ram #(.WIDTH(128), .DEPTH(TABLE_DEPTH)) u_ctr (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (p_q),
		.wdata (ctr_wd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ctr_rd)
	);

	// shared adder: packets in one cycle, bytes in the next
	logic [63:0] add_a;
	logic [63:0] add_b;
	logic [63:0] add_sum;
	assign add_a = (state_q == S_ADDP) ? ctr_q[127:64] : ctr_q[63:0];
	assign add_b = (state_q == S_ADDP) ? 64'(pdelta_q) : 64'(bdelta_q);

	fctu_add u_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	// store control
	always_comb begin
		used_we = 1'b0;
		used_wd = 1'b0;
		used_wa = p_q;
		ctr_we  = 1'b0;
		ctr_wd  = {psum_q, add_sum};
		rd_en   = 1'b0;
		rd_addr = p_q;
		case (state_q)
			S_CLR: begin
				used_we = 1'b1;
				used_wa = clr_q;
			end
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = off_w[AW-1:0];
			end
			S_ARD: begin
				rd_en = 1'b1;
			end
			S_ACHK: begin
				if (!used_rd) begin
					used_we = 1'b1;
					used_wd = 1'b1;
					ctr_we  = 1'b1;
					ctr_wd  = '0;
				end
			end
			S_OCHK: begin
				if (used_rd && op_q == fctu_pkg::OP_FREE) begin
					used_we = 1'b1;
				end
			end
			S_ADDB: begin
				ctr_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			count_q <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == fctu_pkg::REG_INDEX_START) begin
				start_q <= cfg_data;
			end else if (cfg_index == fctu_pkg::REG_COUNTER_COUNT) begin
				count_q <= cfg_data[10:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			cursor_q   <= '0;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result taken; S_FIN reloads the register itself
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (in_op == fctu_pkg::OP_ALLOC) begin
							state_q <= (n_w == '0) ? S_FIN : S_ARD;
						end else begin
							state_q <= in_ok ? S_OCHK : S_FIN;
						end
					end
				end
				S_ARD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (!used_rd) begin
						used_q   <= used_q + UCW'(1);
						cursor_q <= start_q + 16'(p_q) + 16'd1;
						state_q  <= S_FIN;
					end else if (k_q + WW'(1) == n_w) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_ARD;
					end
				end
				S_OCHK: begin
					if (!used_rd) begin
						state_q <= S_FIN;
					end else if (op_q == fctu_pkg::OP_INCR) begin
						state_q <= S_ADDP;
					end else begin
						if (op_q == fctu_pkg::OP_FREE) begin
							used_q <= used_q - UCW'(1);
						end
						state_q <= S_FIN;
					end
				end
				S_ADDP: begin
					state_q <= S_ADDB;
				end
				S_ADDB: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= in_op;
					bdelta_q  <= in_bd;
					pdelta_q  <= in_pd;
					inrange_q <= in_ge;
					p_q       <= (in_op == fctu_pkg::OP_ALLOC) ? first_slot : off_w[AW-1:0];
					k_q       <= '0;
					r_alloc_q <= '0;
					r_ptot_q  <= '0;
					r_btot_q  <= '0;
					if (in_op == fctu_pkg::OP_ALLOC) begin
						r_status_q <= fctu_pkg::ST_NO_SPACE;
					end else begin
						r_status_q <= in_ok ? fctu_pkg::ST_OK : fctu_pkg::ST_NOT_ALLOC;
					end
				end
			end
			S_ACHK: begin
				if (!used_rd) begin
					r_status_q <= fctu_pkg::ST_OK;
					r_alloc_q  <= start_q + 16'(p_q);
				end else begin
					p_q <= p_next;
					k_q <= k_q + WW'(1);
				end
			end
			S_OCHK: begin
				ctr_q <= ctr_rd;
				if (!used_rd) begin
					r_status_q <= fctu_pkg::ST_NOT_ALLOC;
				end else if (op_q == fctu_pkg::OP_READ) begin
					r_ptot_q <= ctr_rd[127:64];
					r_btot_q <= ctr_rd[63:0];
				end
			end
			S_ADDP: begin
				psum_q <= add_sum;
			end
			S_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {2'b00, inrange_q, 11'(used_q), r_btot_q, r_ptot_q,
						r_alloc_q, r_status_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTH
	// no item taken while the used flags are being cleared
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !s_tready)
		else $error("item accepted during clear");

	// occupancy never exceeds the table
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		UCW'(used_q) <= UCW'(TABLE_DEPTH))
		else $error("used count beyond table depth");

	// an accepted item occupies the sequencer on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready right after accept");

	// the probe count stays inside the window during a search
	a_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACHK) |-> (k_q < n_w))
		else $error("search ran past the window");
`endif

endmodule

FILE: hw/rtl/fctu_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module fctu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/fctu_add.sv
// Shared 64-bit adder used for both counter updates of an increment.
// No dependencies.
module fctu_add (
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] sum
);

	// wraps modulo 2^64
	assign sum = a + b;

endmodule

FILE: tb/fctu_checker.sv
// Checker for the flow counter table unit: watches the item, result and
// register channels, keeps its own copy of the table and compares results.
// Depends on fctu_pkg.
module fctu_checker #(
	parameter int unsigned TABLE_DEPTH = fctu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [fctu_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [fctu_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fctu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fctu_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);

	typedef struct {
		logic [1:0]  status;
		logic [15:0] alloc_idx;
		logic [63:0] pkt_total;
		logic [63:0] byte_total;
		logic [10:0] occupancy;
		logic        in_range;
	} table_result_t;

	// mirror of the table state
	bit          slot_used [TABLE_DEPTH];
	logic [63:0] slot_pkts [TABLE_DEPTH];
	logic [63:0] slot_bytes [TABLE_DEPTH];
	logic [15:0] win_start;
	logic [10:0] win_count;
	logic [15:0] cursor;
	logic [10:0] used_total;

	table_result_t awaited_results[$];

	assign pending = awaited_results.size();

	// usable window: register value clipped to depth and to the 16-bit space
	function automatic int win_size();
		int n;
		n = win_count;
		if (n > TABLE_DEPTH)
			n = TABLE_DEPTH;
		if (n > 65536 - int'(win_start))
			n = 65536 - int'(win_start);
		return n;
	endfunction

	task automatic predict_table_item(input logic [fctu_pkg::IN_DATA_W-1:0] d,
			output table_result_t r);
		logic [1:0]  op;
		logic [15:0] idx;
		int          n;
		int          first;
		int          off;
		int          slot;
		bit          hit;
		op = d[1:0];
		idx = d[17:2];
		r = '{default: '0};
		n = win_size();
		slot = int'(idx) - int'(win_start);
		hit = (idx >= win_start) && (slot < n) && slot_used[slot];
		if (op == fctu_pkg::OP_ALLOC) begin
			first = 0;
			if (cursor >= win_start && int'(cursor) - int'(win_start) < n)
				first = int'(cursor) - int'(win_start);
			slot = -1;
			for (int k = 0; k < n; k++) begin
				off = (first + k) % n;
				if (!slot_used[off]) begin
					slot = off;
					break;
				end
			end
			if (slot >= 0) begin
				slot_used[slot] = 1'b1;
				slot_pkts[slot] = '0;
				slot_bytes[slot] = '0;
				used_total++;
				r.alloc_idx = win_start + 16'(slot);
				cursor = r.alloc_idx + 16'd1;
			end else begin
				r.status = fctu_pkg::ST_NO_SPACE;
			end
		end else if (!hit) begin
			r.status = fctu_pkg::ST_NOT_ALLOC;
		end else if (op == fctu_pkg::OP_FREE) begin
			slot_used[slot] = 1'b0;
			used_total--;
		end else if (op == fctu_pkg::OP_INCR) begin
			slot_bytes[slot] += 64'(d[49:18]);
			slot_pkts[slot] += 64'(d[81:50]);
		end else begin
			r.pkt_total = slot_pkts[slot];
			r.byte_total = slot_bytes[slot];
		end
		r.occupancy = used_total;
		r.in_range = (idx >= win_start);
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		table_result_t got;
		if (!arst_n) begin
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_pkts[i] = '0;
				slot_bytes[i] = '0;
			end
			win_start = '0;
			win_count = 11'd1024;
			cursor = '0;
			used_total = '0;
			fail_count = 0;
			awaited_results.delete();
		end else begin
			// result side first: it always belongs to an older item
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.alloc_idx = m_tdata[17:2];
				got.pkt_total = m_tdata[81:18];
				got.byte_total = m_tdata[145:82];
				got.occupancy = m_tdata[156:146];
				got.in_range = m_tdata[157];
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: %h", m_tdata);
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.alloc_idx !== want.alloc_idx ||
							got.pkt_total !== want.pkt_total ||
							got.byte_total !== want.byte_total ||
							got.occupancy !== want.occupancy ||
							got.in_range !== want.in_range) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("mismatch: exp st=%0d idx=%0d pk=%0d by=%0d occ=%0d inr=%0d,",
								want.status, want.alloc_idx, want.pkt_total,
								want.byte_total, want.occupancy, want.in_range);
							$display(" got st=%0d idx=%0d pk=%0d by=%0d occ=%0d inr=%0d",
								got.status, got.alloc_idx, got.pkt_total,
								got.byte_total, got.occupancy, got.in_range);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_table_item(s_tdata, want);
				awaited_results.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fctu_pkg::REG_INDEX_START)
					win_start = cfg_data;
				else if (cfg_index == fctu_pkg::REG_COUNTER_COUNT)
					win_count = cfg_data[10:0];
			end
		end
	end

endmodule

FILE: tb/flow_counter_table_unit_test.sv
// Testbench top for the flow counter table unit: drives items, results
// back-pressure and register writes; the verdict comes from fctu_checker.
// Depends on fctu_pkg, flow_counter_table_unit and fctu_checker.
module flow_counter_table_unit_test;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [fctu_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [fctu_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [fctu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fctu_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              fail_count;
	int                              pending;
	bit                              no_gaps;
	int                              results_taken;

	flow_counter_table_unit u_dut (.*);

	fctu_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit, well above the slowest legal run
	initial begin
		#300_000_000;
		$display("flow_counter_table_unit regression: fail");
		$finish;
	end

	// result side: random stalls, one long hold-off while items keep coming
	initial begin
		int gap;
		m_tready = 1'b0;
		results_taken = 0;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 9);
			if (results_taken == 400)
				gap = 500;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_taken++;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [15:0] idx,
			input logic [31:0] bdelta, input logic [31:0] pdelta);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, pdelta, bdelta, idx, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// only between phases: all results in, then a short settle
	task automatic write_reg(input logic [fctu_pkg::CFG_IDX_W-1:0] ridx,
			input logic [15:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ridx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF;
			1: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// mostly indices inside or just around the window, some anywhere
	task automatic random_item(input int wstart, input int wcount);
		int          r;
		logic [1:0]  op;
		logic [15:0] idx;
		r = $urandom_range(0, 99);
		op = (r < 30) ? fctu_pkg::OP_ALLOC : (r < 45) ? fctu_pkg::OP_FREE :
			(r < 75) ? fctu_pkg::OP_INCR : fctu_pkg::OP_READ;
		r = $urandom_range(0, 19);
		if (r == 0)
			idx = 16'($urandom);
		else if (r == 1)
			idx = 16'(wstart - 1 - $urandom_range(0, 3));
		else
			idx = 16'(wstart + $urandom_range(0, wcount + 1));
		send_item(op, idx, pick_delta(), pick_delta());
	endtask

	initial begin
		int starts[8] = '{100, 0, 65530, 65535, 0, 500, 96, 1000};
		int counts[8] = '{16, 0, 1024, 1, 1024, 32, 24, 2047};
		int lens[8] = '{150, 20, 60, 20, 50, 200, 150, 90};
		int wcnt;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default window [0, 1024)
		send_item(fctu_pkg::OP_ALLOC, 16'd0, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_INCR, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(fctu_pkg::OP_INCR, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(fctu_pkg::OP_READ, 16'd0, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_READ, 16'd5, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_INCR, 16'd1023, 32'd1, 32'd1);
		send_item(fctu_pkg::OP_READ, 16'hFFFF, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_FREE, 16'd1024, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_ALLOC, 16'hFFFF, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_ALLOC, 16'd0, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_FREE, 16'd0, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_FREE, 16'd0, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_INCR, 16'd1, 32'hAAAA_5555, 32'h5555_AAAA);
		send_item(fctu_pkg::OP_READ, 16'd1, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_ALLOC, 16'd0, 32'd0, 32'd0);
		send_item(fctu_pkg::OP_READ, 16'd3, 32'd0, 32'd0);

		// phases over several windows; odd phases run without gaps
		for (int p = 0; p < 8; p++) begin
			write_reg(fctu_pkg::REG_INDEX_START, 16'(starts[p]));
			write_reg(fctu_pkg::REG_COUNTER_COUNT, 16'(counts[p]));
			no_gaps = p[0];
			wcnt = (counts[p] > 1024) ? 1024 : counts[p];
			if (p == 3) begin
				// single slot at the top of the index space: cursor wraps
				send_item(fctu_pkg::OP_ALLOC, 16'hFFFF, 32'd0, 32'd0);
				send_item(fctu_pkg::OP_ALLOC, 16'hFFFF, 32'd0, 32'd0);
				send_item(fctu_pkg::OP_INCR, 16'hFFFF, 32'd7, 32'd3);
				send_item(fctu_pkg::OP_READ, 16'hFFFF, 32'd0, 32'd0);
			end
			for (int i = 0; i < lens[p]; i++)
				random_item(starts[p], wcnt);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("flow_counter_table_unit regression: pass");
		else
			$display("flow_counter_table_unit regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/fctu_pkg.sv
hw/rtl/fctu_ram.sv
hw/rtl/fctu_add.sv
hw/rtl/flow_counter_table_unit.sv
tb/fctu_checker.sv
tb/flow_counter_table_unit_test.sv
